// ===== sv/dprt_pkg.sv =====
// Package: shared types and codes for the donated page range tracker.
package dprt_pkg;

    typedef enum logic [2:0] {
        ACT_ADD       = 3'd0,
        ACT_REMOVE    = 3'd1,
        ACT_QUERY     = 3'd2,
        ACT_QUERY_ANY = 3'd3,
        ACT_CLEAR     = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] guest_id;
        logic [51:0] page_frame;
    } cmd_t;

endpackage

// ===== sv/donated_page_range_tracker_unit.sv =====
// An accepted beat passes through the queue, the compare registers and the result register.
// The table engine takes no new beat while one is in compare or update, or
// while its result still waits in the result register to be taken.
// Reset: asynchronous, active low; all ranges are freed and the queue emptied.
// A two-entry queue decouples the input side from the table engine.
module donated_page_range_tracker_unit
    import dprt_pkg::*;
#(
    parameter int RANGE_ENTRIES = 64,
    parameter int FRAME_BITS    = 36
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [((FRAME_BITS + 23) / 8) * 8 - 1:0] s_tdata,
                                   // guest_id[15:0], page_frame above it, zero fill
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // hit[0], status[2:1], zero fill
);

    logic q_valid, q_ready;
    cmd_t q_cmd;

    dprt_front #(.FRAME_BITS(FRAME_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_action(s_tuser), .in_guest(s_tdata[15:0]),
        .in_frame(s_tdata[16 +: FRAME_BITS]),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    dprt_back #(.RANGE_ENTRIES(RANGE_ENTRIES), .FRAME_BITS(FRAME_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
    );

endmodule

// ===== sv/dprt_front.sv =====
// Front end: accepts input beats and queues them for the table engine.
module dprt_front
    import dprt_pkg::*;
#(
    parameter int FRAME_BITS = 36
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  in_action,
    input  logic [15:0] in_guest,
    input  logic [FRAME_BITS-1:0] in_frame,
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_cmd
);

    cmd_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next, wr_reg, wr_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
        wr_next  = wr_reg ^ push;
        rd_next  = rd_reg ^ pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg].action     <= in_action;
            q_reg[wr_reg].guest_id   <= in_guest;
            q_reg[wr_reg].page_frame <= 52'(in_frame);
        end
    end

endmodule

// ===== sv/dprt_back.sv =====
// Back end: parallel compare over all range cells, registered, then a table update.
module dprt_back
    import dprt_pkg::*;
#(
    parameter int RANGE_ENTRIES = 64,
    parameter int FRAME_BITS    = 36
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    output logic       q_ready,
    input  cmd_t       q_cmd,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_data
);

    localparam int IW = (RANGE_ENTRIES > 1) ? $clog2(RANGE_ENTRIES) : 1;
    localparam int CW = FRAME_BITS + 1;

    logic [RANGE_ENTRIES-1:0] valid_reg;
    logic [15:0]              guest_reg [RANGE_ENTRIES];
    logic [FRAME_BITS-1:0]    start_reg [RANGE_ENTRIES];
    logic [CW-1:0]            count_reg [RANGE_ENTRIES];

    logic [RANGE_ENTRIES-1:0] hold_g, hold_a, below_m, above_m, gmatch;
    logic [RANGE_ENTRIES-1:0] hold_g_reg, hold_a_reg, below_reg, above_reg, gmatch_reg;
    logic                     busy_reg;
    cmd_t                     cmd_reg;
    logic                     ov_reg;
    logic                     hit_reg, hit_next;
    logic [1:0]               st_reg, st_next;
    logic [FRAME_BITS-1:0]    pf, cpf;

    assign pf  = q_cmd.page_frame[FRAME_BITS-1:0];
    assign cpf = cmd_reg.page_frame[FRAME_BITS-1:0];

    always_comb
    begin
        for (int i = 0; i < RANGE_ENTRIES; i++)
        begin
            logic [CW-1:0] off, endp;
            off  = CW'(pf) - CW'(start_reg[i]);
            endp = CW'(start_reg[i]) + count_reg[i];
            hold_a[i]  = valid_reg[i] && (pf >= start_reg[i]) && (off < count_reg[i]);
            gmatch[i]  = valid_reg[i] && (guest_reg[i] == q_cmd.guest_id);
            hold_g[i]  = hold_a[i] && gmatch[i];
            below_m[i] = gmatch[i] && (CW'(start_reg[i]) == CW'(pf) + CW'(1));
            above_m[i] = gmatch[i] && (endp == CW'(pf));
        end
    end

    logic          f_hg, f_b, f_a, f_fr;
    logic [IW-1:0] i_hg, i_b, i_a, i_fr;

    always_comb
    begin
        f_hg = 1'b0; f_b = 1'b0; f_a = 1'b0; f_fr = 1'b0;
        i_hg = '0; i_b = '0; i_a = '0; i_fr = '0;
        for (int i = RANGE_ENTRIES - 1; i >= 0; i--)
        begin
            if (hold_g_reg[i]) begin f_hg = 1'b1; i_hg = IW'(i); end
            if (below_reg[i])  begin f_b  = 1'b1; i_b  = IW'(i); end
            if (above_reg[i])  begin f_a  = 1'b1; i_a  = IW'(i); end
            if (!valid_reg[i]) begin f_fr = 1'b1; i_fr = IW'(i); end
        end
    end

    assign q_ready = !busy_reg && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = {5'd0, st_reg, hit_reg};

    logic [FRAME_BITS-1:0] s_sel;
    logic [CW-1:0]         c_sel;
    assign s_sel = start_reg[i_hg];
    assign c_sel = count_reg[i_hg];

    always_comb
    begin
        hit_next = 1'b0;
        st_next  = ST_OK;
        case (cmd_reg.action)
            ACT_ADD:
                if (!f_hg && !f_b && !f_a && !f_fr) st_next = ST_FULL;
            ACT_REMOVE:
                if (!f_hg) st_next = ST_NOTFOUND;
                else if (c_sel != CW'(1) && CW'(cpf) != CW'(s_sel) + c_sel - CW'(1)
                         && cpf != s_sel && !f_fr)
                    st_next = ST_FULL;
            ACT_QUERY:
            begin
                hit_next = |hold_g_reg;
                st_next  = hit_next ? ST_OK : ST_NOTFOUND;
            end
            ACT_QUERY_ANY:
            begin
                hit_next = |hold_a_reg;
                st_next  = hit_next ? ST_OK : ST_NOTFOUND;
            end
            ACT_CLEAR:
            begin
                hit_next = |gmatch_reg;
                st_next  = hit_next ? ST_OK : ST_NOTFOUND;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            busy_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready) ov_reg <= 1'b0;
            if (q_valid && q_ready) busy_reg <= 1'b1;
            if (busy_reg)
            begin
                busy_reg <= 1'b0;
                ov_reg   <= 1'b1;
                case (cmd_reg.action)
                    ACT_ADD:
                        if (!f_hg && !f_b && !f_a && f_fr) valid_reg[i_fr] <= 1'b1;
                    ACT_REMOVE:
                        if (f_hg)
                        begin
                            if (c_sel == CW'(1)) valid_reg[i_hg] <= 1'b0;
                            else if (CW'(cpf) != CW'(s_sel) + c_sel - CW'(1)
                                     && cpf != s_sel && f_fr)
                                valid_reg[i_fr] <= 1'b1;
                        end
                    ACT_CLEAR:
                        valid_reg <= valid_reg & ~gmatch_reg;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            cmd_reg    <= q_cmd;
            hold_g_reg <= hold_g;
            hold_a_reg <= hold_a;
            below_reg  <= below_m;
            above_reg  <= above_m;
            gmatch_reg <= gmatch;
        end
        if (busy_reg)
        begin
            hit_reg <= hit_next;
            st_reg  <= st_next;
            case (cmd_reg.action)
                ACT_ADD:
                    if (!f_hg)
                    begin
                        if (f_b)
                        begin
                            start_reg[i_b] <= cpf;
                            count_reg[i_b] <= count_reg[i_b] + CW'(1);
                        end
                        else if (f_a)
                            count_reg[i_a] <= count_reg[i_a] + CW'(1);
                        else if (f_fr)
                        begin
                            guest_reg[i_fr] <= cmd_reg.guest_id;
                            start_reg[i_fr] <= cpf;
                            count_reg[i_fr] <= CW'(1);
                        end
                    end
                ACT_REMOVE:
                    if (f_hg && c_sel != CW'(1))
                    begin
                        if (CW'(cpf) == CW'(s_sel) + c_sel - CW'(1))
                            count_reg[i_hg] <= c_sel - CW'(1);
                        else if (cpf == s_sel)
                        begin
                            start_reg[i_hg] <= s_sel + FRAME_BITS'(1);
                            count_reg[i_hg] <= c_sel - CW'(1);
                        end
                        else if (f_fr)
                        begin
                            count_reg[i_hg] <= CW'(cpf) - CW'(s_sel);
                            guest_reg[i_fr] <= cmd_reg.guest_id;
                            start_reg[i_fr] <= cpf + FRAME_BITS'(1);
                            count_reg[i_fr] <= CW'(s_sel) + c_sel - CW'(cpf) - CW'(1);
                        end
                    end
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/dprt_checker.sv =====
// Checker: port-level properties of the tracker, bound to the top level.
module dprt_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:1] != 2'd3)
        else $error("reserved status code");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:3] == 5'd0)
        else $error("padding bits set");

    a_hitok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[2:1] == 2'd0)
        else $error("hit with non-ok status");

endmodule

bind donated_page_range_tracker_unit dprt_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
